// ===== rtl/swec_pkg.sv =====
// Shared constants and control types for the sliding-window event counter.
`default_nettype none
package swec_pkg;

    localparam int FIFO_DEPTH   = 1024;
    localparam int ADDR_W       = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W        = $clog2(FIFO_DEPTH + 1);
    localparam int TIME_W       = 30;
    localparam int OUT_CNT_W    = 11;
    localparam logic [TIME_W-1:0] WINDOW_RESET = TIME_W'(3000);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXPIRE
    } state_t;

    typedef struct packed {
        logic load;
        logic pop;
        logic finish;
    } swec_cmd_t;

    typedef struct packed {
        logic expire;
    } swec_status_t;

endpackage
`default_nettype wire

// ===== rtl/swec_ctrl.sv =====
// Controller state machine: expiry loop, completion and result handshake.
`default_nettype none
module swec_ctrl
    import swec_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         event_valid,
    output logic              event_stall,
    output logic              result_valid,
    input  wire logic         result_stall,
    input  wire swec_status_t status,
    output swec_cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;
    logic   result_valid_reg;
    logic   result_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        cmd               = '0;
        event_stall       = 1'b1;
        result_valid_next = result_valid_reg && result_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                event_stall = 1'b0;
                if (event_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXPIRE;
                end
            end
            ST_EXPIRE:
            begin
                if (status.expire)
                begin
                    cmd.pop = 1'b1;
                end
                else if (!result_valid_reg || !result_stall)
                begin
                    // load the result register and release the input side
                    cmd.finish        = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_valid = result_valid_reg;

endmodule
`default_nettype wire

// ===== rtl/swec_datapath.sv =====
// Datapath: timestamp store, head/tail pointers, count, window compare and result.
`default_nettype none
module swec_datapath
    import swec_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [TIME_W-1:0] cfg_data,
    input  wire logic [TIME_W-1:0] event_time,
    input  wire swec_cmd_t         cmd,
    output swec_status_t           status,
    output logic [OUT_CNT_W-1:0]   events_in_window,
    output logic                   overflow
);

    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(FIFO_DEPTH);

    logic [TIME_W-1:0]    time_store [FIFO_DEPTH];
    logic [TIME_W-1:0]    head_time_reg;
    logic [TIME_W-1:0]    window_reg;
    logic [TIME_W-1:0]    time_reg;
    logic [ADDR_W-1:0]    head_reg;
    logic [ADDR_W-1:0]    head_next;
    logic [ADDR_W-1:0]    tail_reg;
    logic [ADDR_W-1:0]    tail_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [OUT_CNT_W-1:0] shown_reg;
    logic                 overflow_reg;
    logic [TIME_W:0]      head_limit;
    logic                 full;
    logic                 push;

    assign full       = (count_reg == FULL_CNT);
    assign push       = cmd.finish && !full;
    assign head_limit = {1'b0, head_time_reg} + {1'b0, window_reg};
    assign status.expire = (count_reg != '0) && (head_limit < {1'b0, time_reg});

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.pop)
        begin
            head_next  = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        else if (push)
        begin
            tail_next  = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            window_reg <= WINDOW_RESET;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (cfg_we)
            begin
                window_reg <= cfg_data;
            end
        end
    end

    // read port follows the head; forward a write that lands on it
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            time_store[tail_reg] <= time_reg;
        end
        if (push && (tail_reg == head_next))
        begin
            head_time_reg <= time_reg;
        end
        else
        begin
            head_time_reg <= time_store[head_next];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            time_reg <= event_time;
        end
        if (cmd.finish)
        begin
            overflow_reg <= full;
            shown_reg    <= full ? OUT_CNT_W'(FULL_CNT) : OUT_CNT_W'(count_reg + 1'b1);
        end
    end

    assign events_in_window = shown_reg;
    assign overflow         = overflow_reg;

endmodule
`default_nettype wire

// ===== rtl/sliding_window_event_counter.sv =====
// Top level of the sliding-window event counter: controller plus datapath.
//
// Each event transfer is accepted in ST_IDLE; ST_EXPIRE then pops every stored
// timestamp that has expired, one entry per cycle, since the head compare
// reads the timestamp store through its single registered read port, and
// then appends the new timestamp unless the store is full. Every event expires
// at most once. No new event is accepted until the previous one has finished.
// The result sits in an output register, so a stalled result does not hold up
// acceptance of the next event. The store holds 1024 timestamps and needs no
// clearing after reset.
`default_nettype none
module sliding_window_event_counter
    import swec_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [TIME_W-1:0]    cfg_data,
    input  wire logic                 event_valid,
    output logic                      event_stall,
    input  wire logic [TIME_W-1:0]    event_time,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output logic [OUT_CNT_W-1:0]      events_in_window,
    output logic                      overflow
);

    swec_cmd_t    cmd;
    swec_status_t status;

    swec_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .event_valid  (event_valid),
        .event_stall  (event_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    swec_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_data         (cfg_data),
        .event_time       (event_time),
        .cmd              (cmd),
        .status           (status),
        .events_in_window (events_in_window),
        .overflow         (overflow)
    );

endmodule
`default_nettype wire

// ===== bench/sliding_window_event_counter_tb.sv =====
// Self-checking bench for the sliding-window event counter: timestamp transfers vs. a FIFO predictor.
module sliding_window_event_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swec_pkg::*;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic [OUT_CNT_W-1:0] count;
        logic                 overflow;
    } window_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [TIME_W-1:0]    cfg_data;
    logic                 event_valid;
    logic                 event_stall;
    logic [TIME_W-1:0]    event_time;
    logic                 result_valid;
    logic                 result_stall;
    logic [OUT_CNT_W-1:0] events_in_window;
    logic                 overflow;

    logic [TIME_W-1:0] window_len = WINDOW_RESET;
    logic [TIME_W-1:0] stored_times[$];
    window_result_t    pending_results[$];
    logic [TIME_W-1:0] time_cursor = '0;
    int unsigned       fail_count = 0;
    int unsigned       cycle_count = 0;
    int unsigned       send_idle_pct = 0;
    int unsigned       recv_idle_pct = 0;
    int unsigned       hold_request = 0;

    sliding_window_event_counter dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_data         (cfg_data),
        .event_valid      (event_valid),
        .event_stall      (event_stall),
        .event_time       (event_time),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .events_in_window (events_in_window),
        .overflow         (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin : result_stall_drive
        int unsigned hold_left;
        hold_left = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else
                result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    function automatic window_result_t predict_window_count(input logic [TIME_W-1:0] t);
        window_result_t r;
        while (stored_times.size() > 0 &&
               ({1'b0, stored_times[0]} + {1'b0, window_len}) < {1'b0, t})
            void'(stored_times.pop_front());
        if (stored_times.size() >= FIFO_DEPTH)
        begin
            r.count    = OUT_CNT_W'(FIFO_DEPTH);
            r.overflow = 1'b1;
        end
        else
        begin
            stored_times.push_back(t);
            r.count    = OUT_CNT_W'(stored_times.size());
            r.overflow = 1'b0;
        end
        return r;
    endfunction

    always @(posedge clk)
    begin : result_check
        window_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got count %0d overflow %0b",
                         $time, events_in_window, overflow);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (events_in_window !== want.count)
                begin
                    $display("%0t: events_in_window expected %0d got %0d",
                             $time, want.count, events_in_window);
                    fail_count++;
                end
                if (overflow !== want.overflow)
                begin
                    $display("%0t: overflow expected %0b got %0b",
                             $time, want.overflow, overflow);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_event(input logic [TIME_W-1:0] t);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            event_valid <= 1'b0;
            @(negedge clk);
        end
        event_valid <= 1'b1;
        event_time  <= t;
        @(posedge clk);
        while (event_stall)
            @(posedge clk);
        pending_results.push_back(predict_window_count(t));
    endtask

    task automatic drain_results();
        @(negedge clk);
        event_valid <= 1'b0;
        while (pending_results.size() > 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_window(input logic [TIME_W-1:0] value);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        window_len = value;
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        @(posedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // window after reset, reaching below zero at the start
    task automatic test_default_window();
        send_event('0);
        send_event(30'd1000);
        send_event(30'd3000);
        send_event(30'd3001);
        send_event(30'd7000);
    endtask

    task automatic test_window_extremes();
        write_window('0);
        send_event(30'd10000);
        send_event(30'd10000);
        send_event(30'd10001);
        write_window(TIME_MAX);
        send_event(30'd20000);
        send_event(30'd30000);
    endtask

    // expiry stops at the first head entry still in the window
    task automatic test_out_of_order();
        write_window(30'd100);
        send_event(30'd30050);
        send_event(30'd500);
        send_event(30'd30200);
        send_event(30'd30250);
        send_event(30'd30240);
        send_event(30'd30240);
        send_event(30'd30341);
        time_cursor = 30'd30341;
    endtask

    task automatic test_random_traffic(input int unsigned items);
        logic [TIME_W-1:0] win;
        logic [TIME_W-1:0] t;
        int unsigned       gap_max;
        int unsigned       back;
        int unsigned       pick;
        gap_max = 1;
        for (int n = 0; n < items; n++)
        begin
            if (n % 50 == 0)
            begin
                case ($urandom_range(0, 5))
                    0: win = '0;
                    1: win = TIME_MAX;
                    2: win = WINDOW_RESET;
                    3: win = TIME_W'($urandom_range(1, 64));
                    4: win = TIME_W'($urandom_range(64, 50000));
                    default: win = TIME_W'($urandom);
                endcase
                write_window(win);
                gap_max = (win >> 3) + 1;
                if (gap_max > 65536)
                    gap_max = 65536;
            end
            pick = $urandom_range(0, 99);
            if (pick < 88)
            begin
                time_cursor += TIME_W'($urandom_range(0, 2 * gap_max));
                t = time_cursor;
            end
            else if (pick < 94)
            begin
                back = $urandom_range(0, 4 * gap_max);
                t = (time_cursor > back) ? time_cursor - TIME_W'(back) : '0;
            end
            else if (pick < 97)
                t = time_cursor;
            else
            begin
                time_cursor += TIME_W'($urandom_range(0, 1 << 20));
                t = time_cursor;
            end
            send_event(t);
        end
    endtask

    // hold off the result side while transfers keep coming
    task automatic test_backpressure();
        write_window(30'd5000);
        @(posedge clk);
        hold_request = 300;
        for (int n = 0; n < 24; n++)
        begin
            time_cursor += TIME_W'($urandom_range(0, 400));
            send_event(time_cursor);
        end
    endtask

    task automatic test_fifo_overflow();
        write_window(TIME_MAX);
        for (int n = 0; n < FIFO_DEPTH + 8; n++)
        begin
            time_cursor += TIME_W'($urandom_range(1, 4));
            send_event(time_cursor);
        end
        write_window('0);
        send_event(TIME_MAX);
        send_event(TIME_MAX);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        event_valid = 1'b0;
        event_time  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_idling(29, 81);
        test_default_window();
        test_window_extremes();
        test_out_of_order();
        test_random_traffic(150);

        set_idling(81, 29);
        test_random_traffic(150);

        set_idling(0, 0);
        test_random_traffic(150);
        test_backpressure();
        test_fifo_overflow();

        drain_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/swec_pkg.sv
rtl/swec_ctrl.sv
rtl/swec_datapath.sv
rtl/sliding_window_event_counter.sv
bench/sliding_window_event_counter_tb.sv
